@@ rtl/sba_pkg.sv @@
`default_nettype none

package sba_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
  localparam int CNT_W      = LINK_W;

  localparam int SIZE_W   = 31;
  localparam int ADDR_W   = 32;
  localparam int ID_W     = 6;
  localparam int PREFIX_W = 6;
  localparam int STATUS_W = 2;
  localparam int HOST_W   = 5;
  localparam int GAP_W    = 27;

  localparam logic [LINK_W-1:0]   NO_LINK   = LINK_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]    CNT_FULL  = CNT_W'(MAX_BLOCKS);
  localparam logic [GAP_W-1:0]    GAP_LIMIT = 27'h7ffffff;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVFL = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic [LINK_W-1:0] link;
  } tbl_rd_t;

  typedef struct packed {
    logic              addr_we;
    logic [IDX_W-1:0]  addr_idx;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic              link_we;
    logic [IDX_W-1:0]  link_idx;
    logic [LINK_W-1:0] link;
  } tbl_wr_t;

  typedef struct packed {
    logic [ID_W-1:0]     block_id;
    logic [ADDR_W-1:0]   first_addr;
    logic [ADDR_W-1:0]   last_addr;
    logic [PREFIX_W-1:0] prefix_len;
    logic [STATUS_W-1:0] status;
  } res_t;

  // smallest h with 2^h >= size; bit length of size-1
  function automatic logic [HOST_W-1:0] host_bits(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m;
    logic [HOST_W-1:0] h;
    m = size - SIZE_W'(1);
    h = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i]) h = HOST_W'(i + 1);
    end
    if (size == '0) h = '0;
    return h;
  endfunction

  // bits 1..h-1 set
  function automatic logic [ADDR_W-1:0] mid_mask(input logic [HOST_W-1:0] h);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int i = 1; i < ADDR_W; i++) begin
      m[i] = (HOST_W'(i) < h);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sba_if.sv @@
`default_nettype none

interface sba_in_if
  import sba_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] req_size;

  modport source (output valid, output req_size, input ready);
  modport sink   (input valid, input req_size, output ready);
endinterface

interface sba_out_if
  import sba_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     block_id;
  logic [ADDR_W-1:0]   first_addr;
  logic [ADDR_W-1:0]   last_addr;
  logic [PREFIX_W-1:0] prefix_len;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output block_id, output first_addr, output last_addr,
                  output prefix_len, output status, input ready);
  modport sink   (input valid, input block_id, input first_addr, input last_addr,
                  input prefix_len, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/subnet_block_allocator_core.sv @@
// Subnet block allocator.
// in_ch carries one request beat (req_size); out_ch returns one result beat per
// request: block_id, first_addr, last_addr, prefix_len and status (ok, table full,
// address overflow). Both channels use valid/ready; a beat moves when both are high.
// Allocated blocks sit in a table memory linked in address order from entry 0.
// Each request walks that list once, one entry per cycle, tracking the best-fit
// gap and the highest block at the same time; the walk rate is set by the table's
// registered read feeding the next read address.
// Per request: accept, a walk over the stored entries, place, a link update for
// a stored block, then a load into the output register; an overflow skips the
// link update. The next request can be taken in the cycle after the result loads;
// the longest walk covers 63 stored entries.
// A full table skips the walk and goes straight to the output register; the
// first block skips it too and goes to the place state. Overflow is known only
// after the walk.
// A stalled out_ch holds the result in the output register; the block takes the
// next request meanwhile and waits before its own result if the register is busy.
// Reset empties the table (entry count zero); table contents need no clearing.
`default_nettype none

module subnet_block_allocator_core
  import sba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sba_in_if.sink    in_ch,
  sba_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [HOST_W-1:0] h_r, h_nxt;
  logic [IDX_W-1:0]  cur_idx_r, cur_idx_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [IDX_W-1:0]  prev_idx_r, prev_idx_nxt;
  logic [ADDR_W-1:0] prev_last_r, prev_last_nxt;
  logic              found_r, found_nxt;
  logic [GAP_W-1:0]  best_gap_r, best_gap_nxt;
  logic [ADDR_W-1:0] gap_last_r, gap_last_nxt;
  logic [IDX_W-1:0]  gap_pos_r, gap_pos_nxt;
  logic [LINK_W-1:0] gap_link_r, gap_link_nxt;
  logic [SIZE_W-1:0] top_val_r, top_val_nxt;
  logic [ADDR_W-1:0] top_last_r, top_last_nxt;
  logic [IDX_W-1:0]  top_pos_r, top_pos_nxt;
  logic [LINK_W-1:0] top_link_r, top_link_nxt;
  logic [IDX_W-1:0]  link_pos_r, link_pos_nxt;
  res_t              res_r, res_nxt;

  logic [IDX_W-1:0]  rd_addr;
  tbl_rd_t           rd;
  tbl_wr_t           wr;
  logic              out_free;
  logic              out_load;

  logic [ADDR_W-1:0] gap;
  logic              gap_hit;
  logic              top_hit;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W:0]   sum;
  logic [ADDR_W-1:0] new_first;
  logic [ADDR_W-1:0] new_last;
  logic [HOST_W-1:0] in_h;

  sba_table u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd),
    .wr      (wr)
  );

  sba_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (out_load),
    .res    (res_r),
    .free   (out_free),
    .out_ch (out_ch)
  );

  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign out_load    = (state_r == S_OUT);
  assign in_h        = host_bits(in_ch.req_size);

  // follow the link straight out of the read register
  assign rd_addr = (state_r == S_WALK) ? rd.link[IDX_W-1:0] : '0;

  // gap from the previous entry to the one now read
  assign gap     = rd.first - prev_last_r;
  assign gap_hit = have_prev_r && !gap[ADDR_W-1] && (gap > {1'b0, size_r}) &&
                   (gap[ADDR_W-1:GAP_W] == '0) && (gap[GAP_W-1:0] < best_gap_r);
  assign top_hit = !rd.last[ADDR_W-1] && (rd.last[ADDR_W-2:0] > top_val_r);

  assign mask      = mid_mask(h_r);
  assign base      = found_r ? gap_last_r : top_last_r;
  assign sum       = {1'b0, (base | ADDR_W'(1)) & ~mask} + ((ADDR_W+1)'(1) << h_r);
  assign new_first = sum[ADDR_W-1:0];
  assign new_last  = (new_first & ~ADDR_W'(1)) | mask;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    size_nxt      = size_r;
    h_nxt         = h_r;
    cur_idx_nxt   = cur_idx_r;
    have_prev_nxt = have_prev_r;
    prev_idx_nxt  = prev_idx_r;
    prev_last_nxt = prev_last_r;
    found_nxt     = found_r;
    best_gap_nxt  = best_gap_r;
    gap_last_nxt  = gap_last_r;
    gap_pos_nxt   = gap_pos_r;
    gap_link_nxt  = gap_link_r;
    top_val_nxt   = top_val_r;
    top_last_nxt  = top_last_r;
    top_pos_nxt   = top_pos_r;
    top_link_nxt  = top_link_r;
    link_pos_nxt  = link_pos_r;
    res_nxt       = res_r;
    wr            = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          size_nxt            = in_ch.req_size;
          h_nxt               = in_h;
          cur_idx_nxt         = '0;
          have_prev_nxt       = 1'b0;
          found_nxt           = 1'b0;
          best_gap_nxt        = GAP_LIMIT;
          top_val_nxt         = '0;
          res_nxt.block_id    = '0;
          res_nxt.first_addr  = '0;
          res_nxt.last_addr   = '0;
          res_nxt.prefix_len  = PREFIX_W'(6'd32 - {1'b0, in_h});
          if (count_r == CNT_FULL) begin
            res_nxt.status = ST_FULL;
            state_nxt      = S_OUT;
          end else if (count_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (gap_hit) begin
          found_nxt    = 1'b1;
          best_gap_nxt = gap[GAP_W-1:0];
          gap_last_nxt = prev_last_r;
          gap_pos_nxt  = prev_idx_r;
          gap_link_nxt = LINK_W'(cur_idx_r);
        end
        // entry 0 is the fallback when no last address is positive
        if (!have_prev_r || top_hit) begin
          top_last_nxt = rd.last;
          top_pos_nxt  = cur_idx_r;
          top_link_nxt = rd.link;
        end
        if (top_hit) top_val_nxt = rd.last[ADDR_W-2:0];
        prev_last_nxt = rd.last;
        prev_idx_nxt  = cur_idx_r;
        have_prev_nxt = 1'b1;
        if (rd.link == NO_LINK) begin
          state_nxt = S_PLACE;
        end else begin
          cur_idx_nxt = rd.link[IDX_W-1:0];
        end
      end

      S_PLACE: begin
        if (count_r == '0) begin
          wr.addr_we          = 1'b1;
          wr.addr_idx         = '0;
          wr.first            = ADDR_W'(h_r != '0);
          wr.last             = mask;
          wr.link_we          = 1'b1;
          wr.link_idx         = '0;
          wr.link             = NO_LINK;
          count_nxt           = CNT_W'(1);
          res_nxt.block_id    = '0;
          res_nxt.first_addr  = ADDR_W'(h_r != '0);
          res_nxt.last_addr   = mask;
          res_nxt.status      = ST_OK;
          state_nxt           = S_OUT;
        end else if (sum[ADDR_W]) begin
          res_nxt.status = ST_OVFL;
          state_nxt      = S_OUT;
        end else begin
          wr.addr_we          = 1'b1;
          wr.addr_idx         = count_r[IDX_W-1:0];
          wr.first            = new_first;
          wr.last             = new_last;
          wr.link_we          = 1'b1;
          wr.link_idx         = count_r[IDX_W-1:0];
          wr.link             = found_r ? gap_link_r : top_link_r;
          link_pos_nxt        = found_r ? gap_pos_r : top_pos_r;
          count_nxt           = count_r + CNT_W'(1);
          res_nxt.block_id    = ID_W'(count_r);
          res_nxt.first_addr  = new_first;
          res_nxt.last_addr   = new_last;
          res_nxt.status      = ST_OK;
          state_nxt           = S_LINK;
        end
      end

      S_LINK: begin
        // chosen entry now points at the new one
        wr.link_we  = 1'b1;
        wr.link_idx = link_pos_r;
        wr.link     = LINK_W'(count_r - CNT_W'(1));
        state_nxt   = S_OUT;
      end

      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r      <= size_nxt;
    h_r         <= h_nxt;
    cur_idx_r   <= cur_idx_nxt;
    have_prev_r <= have_prev_nxt;
    prev_idx_r  <= prev_idx_nxt;
    prev_last_r <= prev_last_nxt;
    found_r     <= found_nxt;
    best_gap_r  <= best_gap_nxt;
    gap_last_r  <= gap_last_nxt;
    gap_pos_r   <= gap_pos_nxt;
    gap_link_r  <= gap_link_nxt;
    top_val_r   <= top_val_nxt;
    top_last_r  <= top_last_nxt;
    top_pos_r   <= top_pos_nxt;
    top_link_r  <= top_link_nxt;
    link_pos_r  <= link_pos_nxt;
    res_r       <= res_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/sba_table.sv @@
`default_nettype none

module sba_table
  import sba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] rd_addr,
  output tbl_rd_t               rd_data,
  input  wire tbl_wr_t          wr
);

  logic [2*ADDR_W-1:0] addr_mem [MAX_BLOCKS];
  logic [LINK_W-1:0]   link_mem [MAX_BLOCKS];
  logic [2*ADDR_W-1:0] addr_q;
  logic [LINK_W-1:0]   link_q;

  always_ff @(posedge clk) begin
    if (wr.addr_we) addr_mem[wr.addr_idx] <= {wr.first, wr.last};
    addr_q <= addr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.link_we) link_mem[wr.link_idx] <= wr.link;
    link_q <= link_mem[rd_addr];
  end

  assign rd_data.first = addr_q[2*ADDR_W-1:ADDR_W];
  assign rd_data.last  = addr_q[ADDR_W-1:0];
  assign rd_data.link  = link_q;

endmodule

`default_nettype wire

@@ rtl/sba_out_reg.sv @@
`default_nettype none

module sba_out_reg
  import sba_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  load,
  input  wire res_t  res,
  output logic       free,
  sba_out_if.source  out_ch
);

  logic valid_r;
  res_t data_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) data_r <= res;
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.block_id   = data_r.block_id;
  assign out_ch.first_addr = data_r.first_addr;
  assign out_ch.last_addr  = data_r.last_addr;
  assign out_ch.prefix_len = data_r.prefix_len;
  assign out_ch.status     = data_r.status;

endmodule

`default_nettype wire

@@ tb/sv/subnet_block_allocator_core_test.sv @@
module subnet_block_allocator_core_test
  import sba_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NO_NEXT     = MAX_BLOCKS;
  localparam int ITEMS_TOTAL = 650;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 22;

  logic clk = 1'b0;
  logic rst_n;

  sba_in_if  in_ch ();
  sba_out_if out_ch ();

  subnet_block_allocator_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // shadow of the block table
  logic [ADDR_W-1:0] blk_first [MAX_BLOCKS];
  logic [ADDR_W-1:0] blk_last  [MAX_BLOCKS];
  int                blk_next  [MAX_BLOCKS] = '{default: NO_NEXT};
  int                tbl_count = 0;

  logic [SIZE_W-1:0] req_fifo [$];
  res_t              due_results [$];

  int  n_sent       = 0;
  int  n_results    = 0;
  int  n_errors     = 0;
  int  holds_asked  = 0;
  int  holds_done   = 0;
  int  hold_left    = 0;
  int  cycle_cnt    = 0;
  bit  steady       = 1'b0;

  function automatic int host_width(input logic [SIZE_W-1:0] sz);
    int h;
    h = 0;
    while (h < 32 && (64'd1 << h) < 64'(sz)) h++;
    return h;
  endfunction

  // best-fit gap first, else the highest positive last address
  function automatic int pick_base(input logic [SIZE_W-1:0] sz);
    longint best_gap, gap, top_last, v;
    int     pos, p, nx, steps;
    bit     found;
    best_gap = longint'(GAP_LIMIT);
    pos = 0;
    p = 0;
    steps = 0;
    found = 1'b0;
    while (steps < tbl_count && blk_next[p] < tbl_count) begin
      nx = blk_next[p];
      gap = longint'($signed(blk_first[nx] - blk_last[p]));
      if (gap > longint'(sz) && gap < best_gap) begin
        best_gap = gap;
        pos = p;
        found = 1'b1;
      end
      p = nx;
      steps++;
    end
    if (found) return pos;
    pos = 0;
    p = 0;
    steps = 0;
    top_last = 0;
    while (steps < tbl_count) begin
      v = longint'($signed(blk_last[p]));
      if (v > top_last) begin
        top_last = v;
        pos = p;
      end
      if (blk_next[p] >= tbl_count) break;
      p = blk_next[p];
      steps++;
    end
    return pos;
  endfunction

  task automatic predict_alloc(input logic [SIZE_W-1:0] sz);
    int                h, pos, n;
    logic [ADDR_W-1:0] mid, lo, hi;
    logic [ADDR_W:0]   sum;
    res_t              r;
    h = host_width(sz);
    mid = (h < 2) ? '0 : ADDR_W'((64'd1 << h) - 64'd2);
    n = tbl_count;
    lo = '0;
    hi = '0;
    r = '0;
    r.prefix_len = PREFIX_W'(ADDR_W - h);
    r.status = ST_OK;
    if (n >= MAX_BLOCKS) begin
      r.status = ST_FULL;
    end else begin
      if (n == 0) begin
        lo = (h > 0) ? ADDR_W'(1) : '0;
        hi = (h > 0) ? ADDR_W'((64'd1 << h) - 64'd2) : '0;
        blk_next[0] = NO_NEXT;
      end else begin
        pos = pick_base(sz);
        sum = {1'b0, (blk_last[pos] | ADDR_W'(1)) & ~mid} + ((ADDR_W+1)'(1) << h);
        if (sum[ADDR_W]) begin
          r.status = ST_OVFL;
        end else begin
          lo = sum[ADDR_W-1:0];
          hi = (lo & ~ADDR_W'(1)) | mid;
          blk_next[n] = blk_next[pos];
          blk_next[pos] = n;
        end
      end
      if (r.status == ST_OK) begin
        blk_first[n] = lo;
        blk_last[n] = hi;
        tbl_count = n + 1;
        r.block_id = ID_W'(n);
        r.first_addr = lo;
        r.last_addr = hi;
      end
    end
    due_results.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    n_errors++;
  endtask

  task automatic send_req(input logic [SIZE_W-1:0] sz);
    while (req_fifo.size() >= 4) @(negedge clk);
    req_fifo.push_back(sz);
    n_sent++;
  endtask

  // mixes small sizes (tight best-fit gaps) with log-uniform sizes over the full range
  function automatic logic [SIZE_W-1:0] rand_size();
    int unsigned h, lo, hi;
    if ($urandom_range(99) < 25) return SIZE_W'($urandom_range(20, 1));
    h = $urandom_range(31, 0);
    if (h == 0) return SIZE_W'($urandom_range(1, 0));
    lo = (32'd1 << (h - 1)) + 1;
    hi = (h == 31) ? 32'h7fffffff : (32'd1 << h);
    return SIZE_W'($urandom_range(hi, lo));
  endfunction

  // request side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_alloc(in_ch.req_size);
      if (in_ch.valid && !in_ch.ready) begin
        // beat still pending, hold it
      end else if (req_fifo.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_ch.valid <= 1'b1;
        in_ch.req_size <= req_fifo.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver stall, counted in cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < holds_asked) begin
      holds_done <= holds_done + 1;
      hold_left <= HOLD_CYCLES;
    end
  end

  // result side
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with nothing outstanding", n_results));
        end else begin
          want = due_results.pop_front();
          if (out_ch.block_id !== want.block_id)
            report_mismatch($sformatf("beat %0d block_id got %0d exp %0d",
                                      n_results, out_ch.block_id, want.block_id));
          if (out_ch.first_addr !== want.first_addr)
            report_mismatch($sformatf("beat %0d first_addr got %h exp %h",
                                      n_results, out_ch.first_addr, want.first_addr));
          if (out_ch.last_addr !== want.last_addr)
            report_mismatch($sformatf("beat %0d last_addr got %h exp %h",
                                      n_results, out_ch.last_addr, want.last_addr));
          if (out_ch.prefix_len !== want.prefix_len)
            report_mismatch($sformatf("beat %0d prefix_len got %0d exp %0d",
                                      n_results, out_ch.prefix_len, want.prefix_len));
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("beat %0d status got %0d exp %0d",
                                      n_results, out_ch.status, want.status));
        end
      end
      out_ch.ready <= (hold_left == 0) && (steady || ($urandom_range(99) >= IDLE_PCT));
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // first block goes at zero: [1, 2]
  task automatic test_first_block();
    send_req(SIZE_W'(4));
  endtask

  // builds a block ending at the top of the space whose successor wraps to a low
  // address, so a best fit onto it carries past bit 31
  task automatic test_overflow_near_top();
    send_req(SIZE_W'(16));
    send_req(SIZE_W'(14));
    send_req(SIZE_W'(32'h7fffffff));
    send_req(SIZE_W'(15));
    send_req(SIZE_W'(16));
    send_req(SIZE_W'(18));
  endtask

  task automatic test_size_extremes();
    send_req(SIZE_W'(0));
    send_req(SIZE_W'(1));
    send_req(SIZE_W'(2));
    send_req(SIZE_W'(3));
    send_req(SIZE_W'(14));
    send_req(SIZE_W'(32'h40000000));
    send_req(SIZE_W'(32'h40000001));
    send_req(SIZE_W'(32'h07fffffe));
    send_req(SIZE_W'(32'h07ffffff));
    send_req(SIZE_W'(32'h08000000));
    send_req(SIZE_W'(32'h7fffffff));
  endtask

  task automatic test_random_fill();
    int k;
    k = 0;
    while (tbl_count < MAX_BLOCKS && k < 400) begin
      if (k == 12) holds_asked++;
      steady = (k >= 25 && k < 45);
      send_req(rand_size());
      k++;
    end
    steady = 1'b0;
  endtask

  // table full: every request bounces; receiver stalls long enough to back up the input
  task automatic test_table_full();
    int k;
    holds_asked++;
    for (k = 0; n_sent < ITEMS_TOTAL; k++) begin
      steady = (k >= 60 && k < 180);
      send_req((k % 5 == 0) ? rand_size() : SIZE_W'($urandom));
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_size = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_first_block();
    test_overflow_near_top();
    test_size_extremes();
    test_random_fill();
    test_table_full();

    while (req_fifo.size() != 0 || in_ch.valid || due_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/sba_pkg.sv
rtl/sba_if.sv
rtl/sba_table.sv
rtl/sba_out_reg.sv
rtl/subnet_block_allocator_core.sv
tb/sv/subnet_block_allocator_core_test.sv
